// ----- hw/rtl/modular_inverse_assert.svh -----
// Assertion macros shared by the modular inverse checker.
`ifndef MODULAR_INVERSE_ASSERT_SVH
`define MODULAR_INVERSE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("modular inverse assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("modular inverse assertion failed");

`endif

// ----- hw/rtl/modinv_pkg.sv -----
// Shared types, constants and state encodings for the modular inverse block.
package modinv_pkg;

  localparam int WIDTH = 31;
  localparam int SHW   = $clog2(WIDTH + 1);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [WIDTH:0]   wide_t;
  typedef logic [SHW-1:0]   shift_t;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_NO_INV = 1'b1;

  typedef struct packed {
    word_t value;
    word_t modulus;
  } in_t;

  typedef struct packed {
    word_t inverse;
    logic  status;
  } out_t;

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
    word_t c;
    word_t acc;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t rem;
    word_t coef;
  } div_rsp_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_SHIFT,
    DIV_SUB
  } div_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_LOOP,
    ST_ROUND,
    ST_FINISH
  } mi_state_t;

endpackage

// ----- hw/rtl/modinv_div.sv -----
// Shift-subtract divider that returns a mod b and acc + (a / b) * c.
module modinv_div import modinv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  div_state_t state_r, state_nxt;
  word_t      a_r, a_nxt;
  wide_t      d_r, d_nxt;
  wide_t      du_r, du_nxt;
  word_t      acc_r, acc_nxt;
  shift_t     s_r, s_nxt;
  logic       done_r, done_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    d_r   <= d_nxt;
    du_r  <= du_nxt;
    acc_r <= acc_nxt;
    s_r   <= s_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    a_nxt     = a_r;
    d_nxt     = d_r;
    du_nxt    = du_r;
    acc_nxt   = acc_r;
    s_nxt     = s_r;
    case (state_r)
      DIV_IDLE: begin
        if (req.start) begin
          a_nxt     = req.a;
          d_nxt     = {1'b0, req.b};
          du_nxt    = {1'b0, req.c};
          acc_nxt   = req.acc;
          s_nxt     = '0;
          state_nxt = DIV_SHIFT;
        end
      end
      DIV_SHIFT: begin
        if (d_r <= {1'b0, a_r}) begin
          d_nxt  = {d_r[WIDTH-1:0], 1'b0};
          du_nxt = {du_r[WIDTH-1:0], 1'b0};
          s_nxt  = s_r + SHW'(1);
        end else begin
          state_nxt = DIV_SUB;
        end
      end
      DIV_SUB: begin
        if (s_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = DIV_IDLE;
        end else begin
          d_nxt  = {1'b0, d_r[WIDTH:1]};
          du_nxt = {1'b0, du_r[WIDTH:1]};
          s_nxt  = s_r - SHW'(1);
          if (a_r >= d_r[WIDTH:1]) begin
            a_nxt   = a_r - d_r[WIDTH:1];
            acc_nxt = acc_r + du_r[WIDTH:1];
          end
        end
      end
      default: begin
        state_nxt = DIV_IDLE;
      end
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.rem  = a_r;
  assign rsp.coef = acc_r;

endmodule

// ----- hw/rtl/modular_inverse.sv -----
// Top level of the modular inverse block: extended Euclidean sequencer.
//
//   channel  ports                       handshake
//   input    start, busy, in_data         beat taken when start is high and busy low
//   result   out_valid, out_data          one-cycle strobe, cannot be held off
//
// A zero modulus gives its result in the cycle after the beat, without using the divider.
// Otherwise the value is first reduced modulo the modulus in a divider pass, and each round
// of the extended Euclidean loop then takes one more divider pass until the remainder is zero.
// The shared divider runs one pass at a time, so busy stays high for the whole of a nonzero-modulus item.
// Reset is synchronous and active low; it returns the sequencer and divider to idle.
// Results are strobed for one cycle and the receiver cannot stall them.
module modular_inverse import modinv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  mi_state_t state_r, state_nxt;
  word_t     n_r, n_nxt;
  word_t     r_r, r_nxt;
  word_t     nr_r, nr_nxt;
  word_t     u_r, u_nxt;
  word_t     nu_r, nu_nxt;
  logic      neg_r, neg_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_t      out_data_r, out_data_nxt;
  div_req_t  req;
  div_rsp_t  rsp;

  modinv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    r_r        <= r_nxt;
    nr_r       <= nr_nxt;
    u_r        <= u_nxt;
    nu_r       <= nu_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    r_nxt         = r_r;
    nr_nxt        = nr_r;
    u_nxt         = u_r;
    nu_nxt        = nu_r;
    neg_nxt       = neg_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    req           = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_data.modulus == '0) begin
            out_valid_nxt        = 1'b1;
            out_data_nxt.inverse = '0;
            out_data_nxt.status  = STATUS_NO_INV;
          end else begin
            req.start = 1'b1;
            req.a     = in_data.value;
            req.b     = in_data.modulus;
            n_nxt     = in_data.modulus;
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (rsp.done) begin
          r_nxt     = n_r;
          nr_nxt    = rsp.rem;
          u_nxt     = '0;
          nu_nxt    = WIDTH'(1);
          neg_nxt   = 1'b1;
          state_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (nr_r == '0) begin
          state_nxt = ST_FINISH;
        end else begin
          req.start = 1'b1;
          req.a     = r_r;
          req.b     = nr_r;
          req.c     = nu_r;
          req.acc   = u_r;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rsp.done) begin
          r_nxt     = nr_r;
          nr_nxt    = rsp.rem;
          u_nxt     = nu_r;
          nu_nxt    = rsp.coef;
          neg_nxt   = !neg_r;
          state_nxt = ST_LOOP;
        end
      end
      ST_FINISH: begin
        out_valid_nxt = 1'b1;
        if (r_r != WIDTH'(1)) begin
          out_data_nxt.inverse = '0;
          out_data_nxt.status  = STATUS_NO_INV;
        end else begin
          out_data_nxt.status = STATUS_OK;
          if (u_r == '0) begin
            out_data_nxt.inverse = '0;
          end else if (neg_r) begin
            out_data_nxt.inverse = n_r - u_r;
          end else if (u_r >= n_r) begin
            out_data_nxt.inverse = u_r - n_r;
          end else begin
            out_data_nxt.inverse = u_r;
          end
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/modinv_checker.sv -----
// Port-level checker for the modular inverse block and its bind.
`include "modular_inverse_assert.svh"

module modinv_checker import modinv_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_data,
  input logic out_valid,
  input out_t out_data
);

  logic beat_in;
  logic mod_zero;
  logic res_no_inv;

  assign beat_in    = start && !busy;
  assign mod_zero   = (in_data.modulus == '0);
  assign res_no_inv = out_valid && (out_data.status == STATUS_NO_INV);

  `MI_ASSERT_SAME(a_no_inv_zero, res_no_inv, out_data.inverse == '0)
  `MI_ASSERT_SAME(a_result_idle, out_valid, !busy)
  `MI_ASSERT_NEXT(a_zero_mod, beat_in && mod_zero, res_no_inv && !busy)
  `MI_ASSERT_NEXT(a_launch, beat_in && !mod_zero, busy && !out_valid)

endmodule

bind modular_inverse modinv_checker u_modinv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
